[rtl/core/traffic_light_sequencer_core_assert.svh]
// assertion macros for the traffic light sequencer core
// expects clk and rst_n in the scope where a macro is used
`ifndef TRAFFIC_LIGHT_SEQUENCER_CORE_ASSERT_SVH
`define TRAFFIC_LIGHT_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TLS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tls check failed");

// next-cycle implication, checked outside reset
`define TLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tls check failed");

`endif

[rtl/core/tls_pkg.sv]
// shared constants, codes and helper functions for the traffic light sequencer
// no dependencies
package tls_pkg;

    localparam int QUARTER_TICKS = 2500;

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int LAMP_W   = 8;
    localparam int PHASE_W  = 4;
    localparam int ELAPSED_W = 32;
    localparam int NUM_PHASES = 9;

    // bound on the largest threshold: four green spans of 511 plus four red spans of 255
    localparam int THR_W = $clog2(QUARTER_TICKS * (4 * 511 + 4 * 255) + 1);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;

    // siren modes
    localparam logic [1:0] MODE_SLAVE_SIREN  = 2'd0;
    localparam logic [1:0] MODE_MASTER_SIREN = 2'd1;
    localparam logic [1:0] MODE_NORMAL       = 2'd2;

    // pending time slots
    localparam logic [1:0] SLOT_NONE   = 2'd0;
    localparam logic [1:0] SLOT_GREEN  = 2'd1;
    localparam logic [1:0] SLOT_YELLOW = 2'd2;
    localparam logic [1:0] SLOT_RED    = 2'd3;

    // characters
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_G     = 8'h67;
    localparam logic [BYTE_W-1:0] CHAR_Y     = 8'h79;
    localparam logic [BYTE_W-1:0] CHAR_R     = 8'h72;
    localparam logic [BYTE_W-1:0] CHAR_I     = 8'h69;
    localparam logic [BYTE_W-1:0] CHAR_X_UP  = 8'h58;
    localparam logic [BYTE_W-1:0] CHAR_Y_UP  = 8'h59;
    localparam logic [BYTE_W-1:0] CHAR_Z_UP  = 8'h5A;

    // forced patterns for the siren modes
    localparam logic [LAMP_W-1:0] PAT_MASTER = 8'b11110000;
    localparam logic [LAMP_W-1:0] PAT_SLAVE  = 8'b00001111;

    // reset spans
    localparam logic [8:0] GREEN_SPAN_RST = 9'd4;
    localparam logic [7:0] RED_SPAN_RST   = 8'd1;

    function automatic logic [LAMP_W-1:0] phase_pattern(input logic [PHASE_W-1:0] k);
        logic [LAMP_W-1:0] p;
        case (k)
            4'd0:    p = 8'b11110000;
            4'd1:    p = 8'b01110000;
            4'd2:    p = 8'b00110000;
            4'd3:    p = 8'b00010000;
            4'd4:    p = 8'b00001111;
            4'd5:    p = 8'b00000111;
            4'd6:    p = 8'b00000011;
            4'd7:    p = 8'b00000001;
            default: p = 8'b00000000;
        endcase
        return p;
    endfunction

    // start time of phase k, from the green and red spans
    function automatic logic [THR_W-1:0] phase_threshold(input logic [8:0] gs,
                                                          input logic [7:0] rs,
                                                          input logic [PHASE_W-1:0] k);
        logic [31:0] g;
        logic [31:0] r;
        logic [31:0] t;
        g = 32'(QUARTER_TICKS) * 32'(gs);
        r = 32'(QUARTER_TICKS) * 32'(rs);
        if (k <= 4'd4) begin
            t = 32'(k) * g;
        end
        else begin
            t = 32'd4 * g + 32'(k - 4'd4) * r;
        end
        return THR_W'(t);
    endfunction

    function automatic logic [BYTE_W-1:0] mode_char(input logic [1:0] m);
        logic [BYTE_W-1:0] c;
        case (m)
            MODE_SLAVE_SIREN:  c = CHAR_X_UP;
            MODE_MASTER_SIREN: c = CHAR_Y_UP;
            default:           c = CHAR_Z_UP;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/traffic_light_sequencer_core.sv]
// traffic light sequencer core: lamp countdown, serial timing setup, siren mode
// depends on tls_pkg and traffic_light_sequencer_core_assert.svh
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | kind, rx_byte
//  out     | out_valid/out_ready | lamp_pattern, yellow_lamp, master_alarm,
//          |                     | slave_alarm, tx_valid, tx_byte
//
// one word in gives exactly one word out, in the cycle after acceptance
// a new word can be taken every cycle; in_ready drops only while a result is
// stalled in the output register
// phase start times are held in registers, recomputed when a timing byte
// arrives, so a tick is only a set of compares against stored values
// rst_n clears all state to its power-up values, lamps off, siren mode normal
`include "traffic_light_sequencer_core_assert.svh"

module traffic_light_sequencer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tls_pkg::KIND_W-1:0]   kind,
    input  logic [tls_pkg::BYTE_W-1:0]   rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tls_pkg::LAMP_W-1:0]   lamp_pattern,
    output logic                         yellow_lamp,
    output logic                         master_alarm,
    output logic                         slave_alarm,
    output logic                         tx_valid,
    output logic [tls_pkg::BYTE_W-1:0]   tx_byte
);
    import tls_pkg::*;

    // time since the cycle start, kept directly instead of tick count minus start
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [1:0]           mode_reg, mode_next;
    logic [1:0]           slot_reg, slot_next;
    logic [BYTE_W-1:0]    green_reg, green_next;
    logic [BYTE_W-1:0]    yellow_reg, yellow_next;
    logic [BYTE_W-1:0]    red_reg, red_next;
    logic [BYTE_W-1:0]    last_byte_reg, last_byte_next;

    // phase start times, one per phase
    logic [THR_W-1:0]     thr_reg [NUM_PHASES];
    logic [THR_W-1:0]     thr_next [NUM_PHASES];

    // lamp state doubles as the output payload
    logic [LAMP_W-1:0]    lamp_reg, lamp_next;
    logic                 yellow_lamp_reg, yellow_lamp_next;
    logic                 master_reg, master_next;
    logic                 slave_reg, slave_next;
    logic                 tx_valid_reg, tx_valid_next;
    logic [BYTE_W-1:0]    tx_byte_reg, tx_byte_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 in_fire;
    logic [PHASE_W-1:0]   reached;
    logic [8:0]           green_span;
    logic [7:0]           red_span;
    logic [BYTE_W-1:0]    slot_value;

    assign in_ready     = !out_valid_reg || out_ready;
    assign in_fire      = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign lamp_pattern = lamp_reg;
    assign yellow_lamp  = yellow_lamp_reg;
    assign master_alarm = master_reg;
    assign slave_alarm  = slave_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_byte      = tx_byte_reg;

    // start times never decrease with phase, so the phases already due form a
    // prefix and their count is the phase the countdown may advance to
    always_comb
    begin
        reached = '0;
        for (int k = 0; k < NUM_PHASES; k++)
        begin
            if (elapsed_reg >= ELAPSED_W'(thr_reg[k]))
            begin
                reached = reached + 4'd1;
            end
        end
    end

    assign slot_value = rx_byte - CHAR_ZERO;

    always_comb
    begin
        elapsed_next     = elapsed_reg;
        phase_next       = phase_reg;
        mode_next        = mode_reg;
        slot_next        = slot_reg;
        green_next       = green_reg;
        yellow_next      = yellow_reg;
        red_next         = red_reg;
        last_byte_next   = last_byte_reg;
        lamp_next        = lamp_reg;
        yellow_lamp_next = yellow_lamp_reg;
        master_next      = master_reg;
        slave_next       = slave_reg;
        tx_valid_next    = tx_valid_reg;
        tx_byte_next     = tx_byte_reg;

        if (in_fire)
        begin
            tx_valid_next = 1'b0;
            tx_byte_next  = '0;
            case (kind)
                KIND_TICK:
                begin
                    elapsed_next = elapsed_reg + 32'd1;
                    case (mode_reg)
                        MODE_NORMAL:
                        begin
                            master_next = 1'b0;
                            slave_next  = 1'b0;
                            if (phase_reg < reached)
                            begin
                                lamp_next  = phase_pattern(reached - 4'd1);
                                phase_next = reached;
                                // last phase lights yellow, first phase clears it
                                if (reached == 4'(NUM_PHASES))
                                begin
                                    yellow_lamp_next = 1'b1;
                                end
                                else if (phase_reg == '0)
                                begin
                                    yellow_lamp_next = 1'b0;
                                end
                            end
                            // restart request: cycle starts at this tick
                            if (last_byte_reg == CHAR_I)
                            begin
                                last_byte_next = CHAR_SPACE;
                                elapsed_next   = 32'd1;
                                phase_next     = '0;
                            end
                        end
                        MODE_MASTER_SIREN:
                        begin
                            lamp_next   = PAT_MASTER;
                            master_next = 1'b1;
                            slave_next  = 1'b0;
                        end
                        MODE_SLAVE_SIREN:
                        begin
                            lamp_next   = PAT_SLAVE;
                            master_next = 1'b0;
                            slave_next  = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                KIND_BYTE:
                begin
                    last_byte_next = rx_byte;
                    case (rx_byte)
                        CHAR_G: slot_next = SLOT_GREEN;
                        CHAR_Y: slot_next = SLOT_YELLOW;
                        CHAR_R: slot_next = SLOT_RED;
                        default:
                        begin
                            case (slot_reg)
                                SLOT_GREEN:  green_next  = slot_value;
                                SLOT_YELLOW: yellow_next = slot_value;
                                SLOT_RED:    red_next    = slot_value;
                                default:
                                begin
                                end
                            endcase
                            slot_next = SLOT_NONE;
                        end
                    endcase
                end
                KIND_BUTTON:
                begin
                    mode_next     = (mode_reg >= MODE_NORMAL) ? MODE_SLAVE_SIREN
                                                              : mode_reg + 2'd1;
                    tx_valid_next = 1'b1;
                    tx_byte_next  = mode_char(mode_next);
                end
                default:
                begin
                end
            endcase
        end
    end

    // spans from the settings as they stand after this word
    assign green_span = {1'b0, green_next} + {1'b0, yellow_next};
    assign red_span   = (red_next > yellow_next) ? red_next - yellow_next : 8'd0;

    always_comb
    begin
        for (int k = 0; k < NUM_PHASES; k++)
        begin
            thr_next[k] = phase_threshold(green_span, red_span, PHASE_W'(k));
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg     <= '0;
            phase_reg       <= '0;
            mode_reg        <= MODE_NORMAL;
            slot_reg        <= SLOT_NONE;
            green_reg       <= '0;
            yellow_reg      <= '0;
            red_reg         <= '0;
            last_byte_reg   <= '0;
            lamp_reg        <= '0;
            yellow_lamp_reg <= 1'b0;
            master_reg      <= 1'b0;
            slave_reg       <= 1'b0;
            tx_valid_reg    <= 1'b0;
            tx_byte_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            elapsed_reg     <= elapsed_next;
            phase_reg       <= phase_next;
            mode_reg        <= mode_next;
            slot_reg        <= slot_next;
            green_reg       <= green_next;
            yellow_reg      <= yellow_next;
            red_reg         <= red_next;
            last_byte_reg   <= last_byte_next;
            lamp_reg        <= lamp_next;
            yellow_lamp_reg <= yellow_lamp_next;
            master_reg      <= master_next;
            slave_reg       <= slave_next;
            tx_valid_reg    <= tx_valid_next;
            tx_byte_reg     <= tx_byte_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // start times follow the timing bytes only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_PHASES; k++)
            begin
                thr_reg[k] <= phase_threshold(GREEN_SPAN_RST, RED_SPAN_RST, PHASE_W'(k));
            end
        end
        else if (in_fire && kind == KIND_BYTE)
        begin
            for (int k = 0; k < NUM_PHASES; k++)
            begin
                thr_reg[k] <= thr_next[k];
            end
        end
    end

    // checks
    `TLS_ASSERT_SAME(a_alarms_exclusive, master_reg, !slave_reg)
    `TLS_ASSERT_SAME(a_tx_char_known, tx_valid_reg, tx_byte_reg == CHAR_X_UP || tx_byte_reg == CHAR_Y_UP || tx_byte_reg == CHAR_Z_UP)
    `TLS_ASSERT_NEXT(a_elapsed_only_on_tick, !(in_fire && kind == KIND_TICK), elapsed_reg == $past(elapsed_reg))
    `TLS_ASSERT_NEXT(a_button_sends_char, in_fire && kind == KIND_BUTTON, out_valid_reg && tx_valid_reg)
    `TLS_ASSERT_NEXT(a_phase_monotonic, in_fire && kind == KIND_TICK && last_byte_reg != CHAR_I, phase_reg >= $past(phase_reg))
    `TLS_ASSERT_SAME(a_phase_bound, out_valid_reg, phase_reg <= 4'(NUM_PHASES))

endmodule
